// ----- hw/rtl/lzsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LZSS decompressor package
// Shared constants, codes and structures of the LZSS stream decompressor.
// ============================================================================
package lzsd_pkg;

    localparam int HISTORY_DEPTH     = 65536;
    localparam int HIST_AW           = $clog2(HISTORY_DEPTH);
    localparam int BYTES_PER_RESULT  = 8;
    localparam int CNT_W             = $clog2(BYTES_PER_RESULT + 1);
    localparam int OUT_DATA_W        = 8 * BYTES_PER_RESULT;
    localparam int OUT_TDATA_W       = ((OUT_DATA_W + CNT_W + 7) / 8) * 8;
    localparam int FRAME_W           = 31;
    localparam int LEN_W             = 9;
    localparam int MIN_MATCH         = 4;
    localparam int FLAGS_PER_CONTROL = 8;
    localparam int FLAGS_W           = 4;
    localparam int DIST_W            = 16;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_DIST_HI = 2'd1,
        PH_LEN     = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_COPY    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_EVAL = 3'd1,
        ST_RD   = 3'd2,
        ST_WR   = 3'd3,
        ST_EMIT = 3'd4
    } state_t;

    // Decoder context that persists between input transfers.
    typedef struct packed {
        logic [7:0]         flag_shift;
        logic [FLAGS_W-1:0] flags_left;
        phase_t             token_phase;
        logic [DIST_W-1:0]  match_distance;
        logic [FRAME_W-1:0] produced_count;
        logic               corrupt;
    } lzsd_ctx_t;

    // Decision for one compressed byte.
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         flag_shift;
        logic [FLAGS_W-1:0] flags_left;
        phase_t             token_phase;
        logic [DIST_W-1:0]  match_distance;
        logic               corrupt;
        logic [LEN_W-1:0]   copy_len;
    } lzsd_eval_t;

    // One result item on its way to the output register.
    typedef struct packed {
        logic [OUT_DATA_W-1:0] data;
        logic [CNT_W-1:0]      count;
        logic                  frame_end;
        logic                  status;
    } lzsd_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lzsd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lzsd_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LZSS token evaluator
// Decides what one compressed byte does, with one shared remaining-count
// subtractor feeding every check against the frame length.
// ============================================================================
module lzsd_eval (
    input  wire logic                        last,
    input  wire logic [7:0]                  byte_in,
    input  wire logic [lzsd_pkg::FRAME_W-1:0] frame_length,
    input  wire lzsd_pkg::lzsd_ctx_t         ctx,
    output lzsd_pkg::lzsd_eval_t             res
);

    logic [lzsd_pkg::FRAME_W:0]   remaining;
    logic                         exhausted;
    logic [lzsd_pkg::LEN_W-1:0]   len;
    logic [lzsd_pkg::LEN_W-1:0]   inc;

    // Bytes still owed to the frame; negative or zero means the frame is full.
    assign remaining = {1'b0, frame_length} - {1'b0, ctx.produced_count};
    assign exhausted = remaining[lzsd_pkg::FRAME_W] || (remaining == '0);
    assign len       = {1'b0, byte_in} + lzsd_pkg::LEN_W'(lzsd_pkg::MIN_MATCH);

    always_comb
    begin
        res.kind           = lzsd_pkg::KIND_NONE;
        res.flag_shift     = ctx.flag_shift;
        res.flags_left     = ctx.flags_left;
        res.token_phase    = ctx.token_phase;
        res.match_distance = ctx.match_distance;
        res.corrupt        = ctx.corrupt;
        res.copy_len       = len;
        inc                = '0;

        if (!ctx.corrupt)
        begin
            if (exhausted)
            begin
                res.corrupt = 1'b1;
            end
            else
            begin
                case (ctx.token_phase)
                    lzsd_pkg::PH_START:
                    begin
                        if (ctx.flags_left == '0)
                        begin
                            res.flag_shift = byte_in;
                            res.flags_left = lzsd_pkg::FLAGS_W'(lzsd_pkg::FLAGS_PER_CONTROL);
                        end
                        else if (ctx.flag_shift[0])
                        begin
                            res.match_distance = {8'd0, byte_in};
                            res.token_phase    = lzsd_pkg::PH_DIST_HI;
                        end
                        else
                        begin
                            res.kind       = lzsd_pkg::KIND_LITERAL;
                            inc            = lzsd_pkg::LEN_W'(1);
                            res.flag_shift = {1'b0, ctx.flag_shift[7:1]};
                            res.flags_left = ctx.flags_left - lzsd_pkg::FLAGS_W'(1);
                        end
                    end
                    lzsd_pkg::PH_DIST_HI:
                    begin
                        res.match_distance = {byte_in, ctx.match_distance[7:0]};
                        res.token_phase    = lzsd_pkg::PH_LEN;
                    end
                    lzsd_pkg::PH_LEN:
                    begin
                        res.token_phase = lzsd_pkg::PH_START;
                        if ((ctx.match_distance == '0) ||
                            ({15'd0, ctx.match_distance} > ctx.produced_count) ||
                            ({23'd0, len} > remaining))
                        begin
                            res.corrupt = 1'b1;
                        end
                        else
                        begin
                            res.kind       = lzsd_pkg::KIND_COPY;
                            inc            = len;
                            res.flag_shift = {1'b0, ctx.flag_shift[7:1]};
                            res.flags_left = ctx.flags_left - lzsd_pkg::FLAGS_W'(1);
                        end
                    end
                    default:
                    begin
                        res.token_phase = lzsd_pkg::PH_START;
                    end
                endcase
            end
        end

        // The frame must end exactly on its length with no token half done.
        if (last && !res.corrupt &&
            ((remaining != {23'd0, inc}) || (res.token_phase != lzsd_pkg::PH_START)))
        begin
            res.corrupt = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lzsd_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LZSS output register
// Holds one result item until the downstream side takes it.
// ============================================================================
module lzsd_out_stage (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire lzsd_pkg::lzsd_result_t              result,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [lzsd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                     m_tlast,
    output logic      [0:0]                          m_tuser
);

    logic                   valid_reg;
    logic                   valid_next;
    lzsd_pkg::lzsd_result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && free)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = lzsd_pkg::OUT_TDATA_W'({result_reg.count, result_reg.data});
    assign m_tlast  = result_reg.frame_end;
    assign m_tuser  = result_reg.status;

endmodule
`default_nettype wire

// ----- hw/rtl/lzss_stream_decompressor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LZSS stream decompressor unit
// Decodes a byte-oriented LZSS stream into frames of a configured length.
// ============================================================================
// Flow: a literal is captured in ST_IDLE, evaluated in ST_EVAL and loaded into the output
// register from ST_EMIT; control and distance bytes free the input after ST_EVAL. A match
// of L bytes holds it for a history read (ST_RD), then a history write (ST_WR), per byte,
// plus an ST_EMIT per result item. Input is taken again only in ST_IDLE; a result
// waits while the output register is full. Reset (rst_n, asynchronous, low) clears the
// context and sets frame_length to 1; the history RAM is not cleared.
// ============================================================================
module lzss_stream_decompressor_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration: frame_length, written whenever cfg_wr_en is high.
    input  wire logic                                cfg_wr_en,
    input  wire logic [lzsd_pkg::FRAME_W-1:0]        cfg_wr_data,
    // Compressed input.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] compressed_byte
    input  wire logic                                s_tlast,   // last_byte
    // Decoded output.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [lzsd_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [63:0] decoded_bytes,
                                                                // [67:64] valid_bytes
    output logic                                     m_tlast,   // frame_end
    output logic      [0:0]                          m_tuser    // [0] status
);

    // Sequencer and decoder context.
    lzsd_pkg::state_t     state_reg;
    lzsd_pkg::state_t     state_next;
    lzsd_pkg::lzsd_ctx_t  ctx_reg;
    lzsd_pkg::lzsd_ctx_t  ctx_next;
    logic [lzsd_pkg::FRAME_W-1:0] frame_length_reg;

    // Captured input transfer.
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;
    logic       in_last_reg;
    logic       in_last_next;

    // Result assembly: bytes gathered for the current result item, and the
    // number of match bytes still to copy.
    logic [lzsd_pkg::OUT_DATA_W-1:0] pack_reg;
    logic [lzsd_pkg::OUT_DATA_W-1:0] pack_next;
    logic [lzsd_pkg::CNT_W-1:0]      pack_cnt_reg;
    logic [lzsd_pkg::CNT_W-1:0]      pack_cnt_next;
    logic [lzsd_pkg::LEN_W-1:0]      left_reg;
    logic [lzsd_pkg::LEN_W-1:0]      left_next;

    lzsd_pkg::lzsd_eval_t   eval_res;
    lzsd_pkg::lzsd_result_t out_result;
    logic                   out_load;
    logic                   out_free;

    // History RAM ports.
    logic                           ram_we;
    logic [lzsd_pkg::HIST_AW-1:0]   ram_waddr;
    logic [7:0]                     ram_wdata;
    logic                           ram_re;
    logic [lzsd_pkg::HIST_AW-1:0]   ram_raddr;
    logic [7:0]                     ram_rdata;

    // The token evaluator sees the byte captured in the previous cycle.
    lzsd_eval u_eval (
        .last         (in_last_reg),
        .byte_in      (in_byte_reg),
        .frame_length (frame_length_reg),
        .ctx          (ctx_reg),
        .res          (eval_res)
    );

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (lzsd_pkg::HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lzsd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (out_result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = (state_reg == lzsd_pkg::ST_IDLE);

    // New history bytes always land at the running output position. A match
    // source is always behind it, and a byte written in a write cycle is read
    // no earlier than the following read cycle, so overlapping copies repeat.
    assign ram_waddr = ctx_reg.produced_count[lzsd_pkg::HIST_AW-1:0];
    assign ram_raddr = ctx_reg.produced_count[lzsd_pkg::HIST_AW-1:0] - ctx_reg.match_distance;
    assign ram_re    = (state_reg == lzsd_pkg::ST_RD);
    assign ram_we    = (state_reg == lzsd_pkg::ST_WR) ||
                       ((state_reg == lzsd_pkg::ST_EVAL) &&
                        (eval_res.kind == lzsd_pkg::KIND_LITERAL));
    assign ram_wdata = (state_reg == lzsd_pkg::ST_WR) ? ram_rdata : in_byte_reg;

    // Every result item of one input carries the status after that input,
    // which the evaluator has settled before the first item leaves.
    assign out_result.data      = pack_reg;
    assign out_result.count     = pack_cnt_reg;
    assign out_result.frame_end = in_last_reg && (left_reg == '0);
    assign out_result.status    = ctx_reg.corrupt;
    assign out_load             = (state_reg == lzsd_pkg::ST_EMIT);

    always_comb
    begin
        state_next    = state_reg;
        ctx_next      = ctx_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        pack_next     = pack_reg;
        pack_cnt_next = pack_cnt_reg;
        left_next     = left_reg;

        case (state_reg)
            lzsd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_byte_next = s_tdata;
                    in_last_next = s_tlast;
                    state_next   = lzsd_pkg::ST_EVAL;
                end
            end
            lzsd_pkg::ST_EVAL:
            begin
                ctx_next.flag_shift     = eval_res.flag_shift;
                ctx_next.flags_left     = eval_res.flags_left;
                ctx_next.token_phase    = eval_res.token_phase;
                ctx_next.match_distance = eval_res.match_distance;
                ctx_next.corrupt        = eval_res.corrupt;
                pack_next               = '0;
                pack_cnt_next           = '0;
                left_next               = '0;
                case (eval_res.kind)
                    lzsd_pkg::KIND_LITERAL:
                    begin
                        ctx_next.produced_count = ctx_reg.produced_count +
                                                  lzsd_pkg::FRAME_W'(1);
                        pack_next     = lzsd_pkg::OUT_DATA_W'(in_byte_reg);
                        pack_cnt_next = lzsd_pkg::CNT_W'(1);
                        state_next    = lzsd_pkg::ST_EMIT;
                    end
                    lzsd_pkg::KIND_COPY:
                    begin
                        left_next  = eval_res.copy_len;
                        state_next = lzsd_pkg::ST_RD;
                    end
                    default:
                    begin
                        // A last byte always closes with a result, even an empty one.
                        state_next = in_last_reg ? lzsd_pkg::ST_EMIT : lzsd_pkg::ST_IDLE;
                    end
                endcase
            end
            lzsd_pkg::ST_RD:
            begin
                state_next = lzsd_pkg::ST_WR;
            end
            lzsd_pkg::ST_WR:
            begin
                ctx_next.produced_count = ctx_reg.produced_count + lzsd_pkg::FRAME_W'(1);
                for (int i = 0; i < lzsd_pkg::BYTES_PER_RESULT; i++)
                begin
                    if (pack_cnt_reg == lzsd_pkg::CNT_W'(i))
                    begin
                        pack_next[8*i +: 8] = ram_rdata;
                    end
                end
                pack_cnt_next = pack_cnt_reg + lzsd_pkg::CNT_W'(1);
                left_next     = left_reg - lzsd_pkg::LEN_W'(1);
                if ((pack_cnt_reg == lzsd_pkg::CNT_W'(lzsd_pkg::BYTES_PER_RESULT - 1)) ||
                    (left_reg == lzsd_pkg::LEN_W'(1)))
                begin
                    state_next = lzsd_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = lzsd_pkg::ST_RD;
                end
            end
            lzsd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    pack_next     = '0;
                    pack_cnt_next = '0;
                    if (left_reg == '0)
                    begin
                        // The frame ends here: the next byte starts a fresh frame.
                        if (in_last_reg)
                        begin
                            ctx_next = '0;
                        end
                        state_next = lzsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lzsd_pkg::ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = lzsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lzsd_pkg::ST_IDLE;
            ctx_reg          <= '0;
            frame_length_reg <= lzsd_pkg::FRAME_W'(1);
            left_reg         <= '0;
            pack_cnt_reg     <= '0;
            in_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ctx_reg      <= ctx_next;
            left_reg     <= left_next;
            pack_cnt_reg <= pack_cnt_next;
            in_last_reg  <= in_last_next;
            if (cfg_wr_en)
            begin
                frame_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        pack_reg    <= pack_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lzsd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// LZSS decompressor port checker
// Watches the top level ports and reports violations of expected behavior.
// ============================================================================
module lzsd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             cfg_wr_en,
    input wire logic [lzsd_pkg::FRAME_W-1:0]     cfg_wr_data,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [7:0]                       s_tdata,
    input wire logic                             s_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [lzsd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tlast,
    input wire logic [0:0]                       m_tuser
);

    logic [lzsd_pkg::CNT_W-1:0] out_count;

    assign out_count = m_tdata[lzsd_pkg::OUT_DATA_W +: lzsd_pkg::CNT_W];

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result claims more bytes than one item holds.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_count <= lzsd_pkg::CNT_W'(lzsd_pkg::BYTES_PER_RESULT))
        else $error("valid byte count out of range");

    // An empty result only appears as the frame-end marker.
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_count == '0) |-> m_tlast)
        else $error("empty result without frame end");

    // The decoder is busy in the cycle after taking a byte.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

endmodule

bind lzss_stream_decompressor_unit lzsd_checker u_lzsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
);
`default_nettype wire

// ----- test/lzss_stream_decompressor_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// LZSS stream decompressor unit test
// Sends compressed frames to the unit and compares every decoded output
// transfer with a decoder written into this bench. Directed frames come
// first, then random frames, most of them well formed and some damaged.
// ============================================================================
module lzss_stream_decompressor_unit_test;

    // Cycles without any transfer before the run is declared hung. The worst
    // case is a 259-byte copy plus long stalls on the output side.
    localparam int          STALL_LIMIT   = 4000;
    // Quiet cycles after the last expected transfer. Control and distance
    // bytes give no output, so a short settle is enough.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RANDOM_ITEMS  = 150;
    localparam int unsigned FRAME_LEN_MAX = 32'd1073741824;

    // Ways a clean random frame gets damaged.
    typedef enum int {
        DMG_CUT,
        DMG_EXTRA,
        DMG_FLIP,
        DMG_NOISE
    } damage_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [lzsd_pkg::FRAME_W-1:0]     cfg_wr_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [lzsd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tlast;
    logic [0:0]                       m_tuser;

    // Decoder state kept by the bench. It mirrors what the unit must hold.
    logic [7:0]                       decoded_history [0:lzsd_pkg::HISTORY_DEPTH-1];
    logic [lzsd_pkg::FRAME_W-1:0]     frame_length_cfg;
    logic [7:0]                       flag_bits;
    logic [lzsd_pkg::FLAGS_W-1:0]     flags_pending;
    lzsd_pkg::phase_t                 token_step;
    logic [lzsd_pkg::DIST_W-1:0]      match_dist;
    logic [lzsd_pkg::FRAME_W-1:0]     decoded_count;
    logic                             frame_broken;

    // Output transfers that are still owed by the unit, oldest first.
    lzsd_pkg::lzsd_result_t           pending_chunks [$];
    // Compressed bytes of the frame that is about to be sent.
    logic [7:0]                       frame_bytes [$];

    int                               error_count;
    int                               bytes_accepted;
    int                               calm_left;

    lzss_stream_decompressor_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [7:0] compressed_byte
        .s_tlast     (s_tlast),     // last_byte
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [63:0] decoded_bytes, [67:64] valid_bytes
        .m_tlast     (m_tlast),     // frame_end
        .m_tuser     (m_tuser)      // [0] status
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Idle lengths shared by both sides. Most gaps are short, a few are long,
    // and now and then a calm stretch with no gaps at all is started.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Decoder of the bench.
    // ------------------------------------------------------------------------
    function automatic void clear_frame_state();
        flag_bits     = '0;
        flags_pending = '0;
        token_step    = lzsd_pkg::PH_START;
        match_dist    = '0;
        decoded_count = '0;
        frame_broken  = 1'b0;
    endfunction

    function automatic void store_byte(input logic [7:0] value);
        decoded_history[decoded_count[lzsd_pkg::HIST_AW-1:0]] = value;
        decoded_count = decoded_count + 1'b1;
    endfunction

    function automatic void advance_flag();
        flag_bits = flag_bits >> 1;
        if (flags_pending != 0)
            flags_pending = flags_pending - 1'b1;
    endfunction

    // Decodes one accepted compressed byte and queues the output transfers
    // that it must cause.
    function automatic void decode_compressed_byte(input logic [7:0] in_byte,
                                                   input logic       in_last);
        logic [7:0]                     out_bytes [$];
        logic [7:0]                     copied;
        logic [lzsd_pkg::HIST_AW-1:0]   src;
        int unsigned                    run_len;
        int unsigned                    room;
        int unsigned                    pos;
        int unsigned                    cnt;
        lzsd_pkg::lzsd_result_t         chunk;

        if (!frame_broken)
        begin
            if (decoded_count >= frame_length_cfg)
            begin
                // The frame is already complete, so this byte is surplus.
                frame_broken = 1'b1;
            end
            else if (token_step == lzsd_pkg::PH_START)
            begin
                if (flags_pending == 0)
                begin
                    flag_bits     = in_byte;
                    flags_pending = lzsd_pkg::FLAGS_W'(lzsd_pkg::FLAGS_PER_CONTROL);
                end
                else if (flag_bits[0])
                begin
                    match_dist = {8'h00, in_byte};
                    token_step = lzsd_pkg::PH_DIST_HI;
                end
                else
                begin
                    store_byte(in_byte);
                    out_bytes.push_back(in_byte);
                    advance_flag();
                end
            end
            else if (token_step == lzsd_pkg::PH_DIST_HI)
            begin
                match_dist[15:8] = in_byte;
                token_step       = lzsd_pkg::PH_LEN;
            end
            else
            begin
                run_len = int'(in_byte) + lzsd_pkg::MIN_MATCH;
                room    = int'(frame_length_cfg - decoded_count);
                if (match_dist == 0 || match_dist > decoded_count || run_len > room)
                begin
                    frame_broken = 1'b1;
                end
                else
                begin
                    // Byte by byte, so an overlapping copy repeats its pattern.
                    for (int k = 0; k < run_len; k++)
                    begin
                        src    = decoded_count[lzsd_pkg::HIST_AW-1:0] - match_dist;
                        copied = decoded_history[src];
                        store_byte(copied);
                        out_bytes.push_back(copied);
                    end
                    advance_flag();
                end
                token_step = lzsd_pkg::PH_START;
            end
        end

        if (in_last && !frame_broken &&
            (decoded_count != frame_length_cfg || token_step != lzsd_pkg::PH_START))
            frame_broken = 1'b1;

        pos = 0;
        do
        begin
            cnt = out_bytes.size() - pos;
            if (cnt > lzsd_pkg::BYTES_PER_RESULT)
                cnt = lzsd_pkg::BYTES_PER_RESULT;
            if (cnt == 0 && !in_last)
                break;
            chunk = '0;
            for (int k = 0; k < cnt; k++)
                chunk.data[8*k +: 8] = out_bytes[pos + k];
            pos             = pos + cnt;
            chunk.count     = lzsd_pkg::CNT_W'(cnt);
            chunk.frame_end = in_last && (pos >= out_bytes.size());
            chunk.status    = frame_broken;
            pending_chunks.push_back(chunk);
        end
        while (pos < out_bytes.size());

        if (in_last)
            clear_frame_state();
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The byte is presented at a falling edge and counts as
    // transferred at the first rising edge with tready high. tvalid stays high
    // after the transfer so a back-to-back byte needs no second assignment in
    // the same step; wait_drained lowers it.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_accepted++;
        decode_compressed_byte(value, is_last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Waits until every owed transfer has come out and the unit has had time
    // to finish any byte that gives no output.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The frame length is only changed while the unit is idle.
    task automatic set_frame_length(input int unsigned value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lzsd_pkg::FRAME_W'(value);
        @(posedge clk);
        frame_length_cfg = lzsd_pkg::FRAME_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_frame(input logic [7:0] values [$]);
        frame_bytes = values;
    endtask

    // Builds a well-formed stream that decodes to exactly total bytes.
    // Unused flags of the final control byte are left random.
    function automatic void build_clean_frame(input int unsigned total);
        int unsigned made;
        int unsigned room;
        int unsigned slot;
        int unsigned ctrl_at;
        int unsigned dist_max;
        int unsigned len_max;
        int unsigned dist_val;
        int unsigned len_val;

        frame_bytes.delete();
        made    = 0;
        slot    = lzsd_pkg::FLAGS_PER_CONTROL;
        ctrl_at = 0;
        while (made < total)
        begin
            if (slot == lzsd_pkg::FLAGS_PER_CONTROL)
            begin
                frame_bytes.push_back(8'($urandom));
                ctrl_at = frame_bytes.size() - 1;
                slot    = 0;
            end
            room = total - made;
            if (made > 0 && room >= lzsd_pkg::MIN_MATCH && $urandom_range(0, 99) < 45)
            begin
                frame_bytes[ctrl_at] = frame_bytes[ctrl_at] | (8'd1 << slot);
                dist_max = (made > 65535) ? 65535 : made;
                if (dist_max > 8 && $urandom_range(0, 99) < 70)
                    dist_max = 8;
                dist_val = $urandom_range(1, dist_max);
                len_max  = (room > lzsd_pkg::MIN_MATCH + 255) ?
                           lzsd_pkg::MIN_MATCH + 255 : room;
                if (len_max > 24 && $urandom_range(0, 99) < 80)
                    len_max = 24;
                len_val  = $urandom_range(lzsd_pkg::MIN_MATCH, len_max);
                frame_bytes.push_back(8'(dist_val));
                frame_bytes.push_back(8'(dist_val >> 8));
                frame_bytes.push_back(8'(len_val - lzsd_pkg::MIN_MATCH));
                made = made + len_val;
            end
            else
            begin
                frame_bytes[ctrl_at] = frame_bytes[ctrl_at] & ~(8'd1 << slot);
                frame_bytes.push_back(8'($urandom));
                made++;
            end
            slot++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Frame length is still at its reset value of 1: a control byte and one
    // literal with all bits set.
    task automatic test_single_literal_frame();
        load_frame('{8'h00, 8'hFF});
        send_frame();
    endtask

    // Two literals, then an overlapping copy of the longest length (distance
    // 2, 259 bytes, 33 transfers) and a copy whose distance needs the high
    // byte. The frame ends exactly on the last copied byte.
    task automatic test_long_overlapping_match();
        set_frame_length(265);
        load_frame('{8'h0C, 8'h5A, 8'hC3, 8'h02, 8'h00, 8'hFF, 8'h02, 8'h01, 8'h00});
        send_frame();
    endtask

    // A zero distance breaks the frame and the bytes after it are ignored;
    // then a distance that reaches before the start of the frame.
    task automatic test_bad_distance();
        set_frame_length(16);
        load_frame('{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E});
        send_frame();
        load_frame('{8'h01, 8'h05, 8'h00, 8'h03});
        send_frame();
    endtask

    // A copy of 5 bytes when only 4 are left in the frame.
    task automatic test_match_overrun();
        set_frame_length(5);
        load_frame('{8'h02, 8'h11, 8'h01, 8'h00, 8'h01});
        send_frame();
    endtask

    // Shortest frame with a surplus byte after it, then a frame of FRAME_LEN_MAX
    // bytes ended in the middle of a copy token.
    task automatic test_leftover_and_early_end();
        set_frame_length(1);
        load_frame('{8'hFE, 8'h80, 8'h33});
        send_frame();
        set_frame_length(FRAME_LEN_MAX);
        load_frame('{8'h01, 8'h01});
        send_frame();
    endtask

    // Phases of one frame length each, with a few frames per phase. Most
    // frames are clean; the rest are cut short, padded, hit in one byte or
    // replaced by noise.
    task automatic test_random_frames();
        int unsigned start_count;
        int unsigned frame_len;
        int unsigned roll;
        int unsigned body;
        int unsigned keep;
        damage_t     damage;

        start_count = bytes_accepted;
        while (bytes_accepted < start_count + RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                frame_len = $urandom_range(1, 40);
            else if (roll < 92)
                frame_len = $urandom_range(41, 300);
            else if (roll < 96)
                frame_len = 1;
            else
                frame_len = FRAME_LEN_MAX;
            set_frame_length(frame_len);
            repeat ($urandom_range(1, 4))
            begin
                // A huge frame cannot be filled here, so it ends early.
                body = (frame_len > 300) ? $urandom_range(1, 40) : frame_len;
                build_clean_frame(body);
                if ($urandom_range(0, 99) < 30)
                begin
                    damage = damage_t'($urandom_range(0, 3));
                    case (damage)
                        DMG_CUT:
                        begin
                            if (frame_bytes.size() > 1)
                            begin
                                keep = $urandom_range(1, frame_bytes.size() - 1);
                                while (frame_bytes.size() > keep)
                                    void'(frame_bytes.pop_back());
                            end
                        end
                        DMG_EXTRA:
                        begin
                            repeat ($urandom_range(1, 3))
                                frame_bytes.push_back(8'($urandom));
                        end
                        DMG_FLIP:
                        begin
                            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
                                8'($urandom);
                        end
                        default:
                        begin
                            frame_bytes.delete();
                            repeat ($urandom_range(1, 12))
                                frame_bytes.push_back(8'($urandom));
                        end
                    endcase
                end
                send_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, and a check of every transfer against the
    // oldest owed one.
    // ------------------------------------------------------------------------
    initial
    begin : sink_pacing
        int stall;
        int hold;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            hold = $urandom_range(1, 12);
            repeat (hold) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : chunk_check
        lzsd_pkg::lzsd_result_t got;
        lzsd_pkg::lzsd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data      = m_tdata[lzsd_pkg::OUT_DATA_W-1:0];
            got.count     = m_tdata[lzsd_pkg::OUT_DATA_W +: lzsd_pkg::CNT_W];
            got.frame_end = m_tlast;
            got.status    = m_tuser[0];
            if (pending_chunks.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer, expected none, actual data %h count %0d",
                         $time, got.data, got.count);
            end
            else
            begin
                want = pending_chunks.pop_front();
                if (got.data !== want.data)
                begin
                    error_count++;
                    $display("%0t: decoded_bytes expected %h actual %h",
                             $time, want.data, got.data);
                end
                if (got.count !== want.count)
                begin
                    error_count++;
                    $display("%0t: valid_bytes expected %0d actual %0d",
                             $time, want.count, got.count);
                end
                if (got.frame_end !== want.frame_end)
                begin
                    error_count++;
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.frame_end, got.frame_end);
                end
                if (got.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, got.status);
                end
            end
        end
    end

    // Hang detection: the run ends if no transfer happens on either side for
    // too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("lzss_stream_decompressor_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        error_count    = 0;
        bytes_accepted = 0;
        calm_left      = 0;
        frame_length_cfg = lzsd_pkg::FRAME_W'(1);
        clear_frame_state();

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_single_literal_frame();
        test_long_overlapping_match();
        test_bad_distance();
        test_match_overrun();
        test_leftover_and_early_end();
        test_random_frames();

        wait_drained();
        if (error_count == 0)
            $display("lzss_stream_decompressor_unit: match");
        else
            $display("lzss_stream_decompressor_unit: mismatch");
        $finish;
    end

endmodule
